// ----- sv/windowed_congestion_rate_monitor_core_assert.svh -----
// assertion macros used by the checker file of the congestion rate monitor
`ifndef WINDOWED_CONGESTION_RATE_MONITOR_CORE_ASSERT_SVH
`define WINDOWED_CONGESTION_RATE_MONITOR_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define WCRM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define WCRM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// same-cycle implication that also runs while reset is held
`define WCRM_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- sv/wcrm_pkg.sv -----
// ----------------------------------------------------------------------------
// wcrm_pkg
// Shared widths, codes and types of the windowed congestion rate monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package wcrm_pkg;

    // field widths
    localparam int SEQ_W    = 32;
    localparam int CNT_W    = 64;
    localparam int TICK_W   = 16;
    localparam int THR_W    = 7;
    localparam int RATE_W   = 15;

    // shared arithmetic unit width: holds congested * 25600 and 100 * congested
    localparam int ACC_W    = 80;

    // stream payload widths
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 216;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALERT_THR    = 2'd1;

    // register reset values
    localparam logic [TICK_W-1:0] WINDOW_TICKS_RST = 16'd100;
    localparam logic [THR_W-1:0]  ALERT_THR_RST    = 7'd20;

    // input kinds
    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // one hundred percent in Q8
    localparam logic [RATE_W-1:0] RATE_FULL = 15'd25600;

    // control of the shared adder
    typedef struct packed {
        logic sub;
    } alu_ctl_t;

endpackage

`default_nettype wire

// ----- sv/windowed_congestion_rate_monitor_core.sv -----
// ----------------------------------------------------------------------------
// windowed_congestion_rate_monitor_core
// Counts packet sequence deltas per window and lifetime, and at window close
// works out the congested percent (Q8) and the threshold alert.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_*       in         tuser: command; tdata: seq_number[31:0], ecn_flag[32]
//  m_*       out        tdata: seq_seen, packet_delta, was_congested,
//                       lifetime_received, lifetime_congested, window_closed,
//                       rate_q8, alert
//  cfg_*     in         cfg_index, cfg_data (register write)
//
//  ticks, baseline and repeated sequence numbers are handled in the idle state.
//  a counted packet passes count and output; one that closes a window also
//  runs range check, scale, divide and alert on the shared 80-bit adder;
//  an empty or fully congested window skips scale and divide.
//  s_tready is low while an item is in work or its result waits for the
//  output register; reset is synchronous, active low.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_congestion_rate_monitor_core
    import wcrm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,   // seq_number[31:0], ecn_flag[32]
    input  wire logic                  s_tuser,   // command[0]
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_DATA_W-1:0]   m_tdata,   // seq_seen[31:0], packet_delta[63:32],
                                                  // was_congested[64],
                                                  // lifetime_received[128:65],
                                                  // lifetime_congested[192:129],
                                                  // window_closed[193], rate_q8[208:194],
                                                  // alert[209]
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_COUNT = 3'd1;
    localparam logic [2:0] S_RANGE = 3'd2;
    localparam logic [2:0] S_SCALE = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_ALERT = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    localparam logic [3:0] DIV_LAST   = 4'd14;
    localparam logic [3:0] ALERT_LAST = 4'd8;

    // control and architectural state
    logic [2:0]        state_reg, state_next;
    logic [3:0]        step_reg, step_next;
    logic [TICK_W-1:0] win_ticks_reg, win_ticks_next;
    logic [THR_W-1:0]  thr_reg, thr_next;
    logic              have_base_reg, have_base_next;
    logic [SEQ_W-1:0]  last_seq_reg, last_seq_next;
    logic [CNT_W-1:0]  win_total_reg, win_total_next;
    logic [CNT_W-1:0]  win_cong_reg, win_cong_next;
    logic [TICK_W-1:0] elapsed_reg, elapsed_next;
    logic [CNT_W-1:0]  tot_rx_reg, tot_rx_next;
    logic [CNT_W-1:0]  tot_cong_reg, tot_cong_next;
    logic [RATE_W-1:0] rate_reg, rate_next;
    logic              alert_reg, alert_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // working payload
    logic [SEQ_W-1:0]    seq_reg, seq_next;
    logic [SEQ_W-1:0]    delta_reg, delta_next;
    logic                ecn_reg, ecn_next;
    logic                closed_reg, closed_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [ACC_W-1:0]    opnd_reg, opnd_next;
    logic [RATE_W-1:0]   quo_reg, quo_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // shared unit
    logic [ACC_W-1:0] alu_a, alu_b, alu_res;
    alu_ctl_t         alu_ctl;
    logic             alu_carry;

    logic [SEQ_W-1:0] in_seq;
    logic             in_ecn;
    logic             in_accept;
    logic [3:0]       thr_step;
    logic             thr_bit;

    assign in_seq    = s_tdata[SEQ_W-1:0];
    assign in_ecn    = s_tdata[SEQ_W];
    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // threshold bit used by the current alert step
    assign thr_step = step_reg - 4'd2;
    assign thr_bit  = thr_reg[thr_step[2:0]];

    // operand selection for the shared adder
    always_comb begin
        alu_a       = acc_reg;
        alu_b       = '0;
        alu_ctl.sub = 1'b0;
        unique case (state_reg)
            S_RANGE: begin
                alu_a       = {16'b0, win_cong_reg};
                alu_b       = {16'b0, win_total_reg};
                alu_ctl.sub = 1'b1;
            end
            S_SCALE: begin
                alu_b = (step_reg == 4'd0) ? {3'b0, win_cong_reg, 13'b0}
                                           : {6'b0, win_cong_reg, 10'b0};
            end
            S_DIV: begin
                alu_b       = opnd_reg;
                alu_ctl.sub = 1'b1;
            end
            S_ALERT: begin
                if (step_reg == 4'd0) begin
                    alu_b = {11'b0, win_cong_reg, 5'b0};
                end else if (step_reg == 4'd1) begin
                    alu_b = {14'b0, win_cong_reg, 2'b0};
                end else begin
                    alu_b       = thr_bit ? opnd_reg : '0;
                    alu_ctl.sub = 1'b1;
                end
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    wcrm_alu u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .ctl   (alu_ctl),
        .res   (alu_res),
        .carry (alu_carry)
    );

    // sequencer and next state
    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        win_ticks_next = win_ticks_reg;
        thr_next       = thr_reg;
        have_base_next = have_base_reg;
        last_seq_next  = last_seq_reg;
        win_total_next = win_total_reg;
        win_cong_next  = win_cong_reg;
        elapsed_next   = elapsed_reg;
        tot_rx_next    = tot_rx_reg;
        tot_cong_next  = tot_cong_reg;
        rate_next      = rate_reg;
        alert_next     = alert_reg;
        m_tvalid_next  = m_tvalid_reg;
        seq_next       = seq_reg;
        delta_next     = delta_reg;
        ecn_next       = ecn_reg;
        closed_next    = closed_reg;
        acc_next       = acc_reg;
        opnd_next      = opnd_reg;
        quo_next       = quo_reg;
        m_tdata_next   = m_tdata_reg;

        // result leaves the output register
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // register writes
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_WINDOW_TICKS: win_ticks_next = cfg_data;
                REG_ALERT_THR:    thr_next       = cfg_data[THR_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    if (s_tuser == CMD_TICK) begin
                        if (elapsed_reg != {TICK_W{1'b1}}) begin
                            elapsed_next = elapsed_reg + 16'd1;
                        end
                    end else if (!have_base_reg) begin
                        have_base_next = 1'b1;
                        last_seq_next  = in_seq;
                    end else if (in_seq != last_seq_reg) begin
                        delta_next    = in_seq - last_seq_reg;
                        last_seq_next = in_seq;
                        seq_next      = in_seq;
                        ecn_next      = in_ecn;
                        state_next    = S_COUNT;
                    end
                end
            end
            // window and lifetime totals
            S_COUNT: begin
                win_total_next = win_total_reg + {32'b0, delta_reg};
                tot_rx_next    = tot_rx_reg + {32'b0, delta_reg};
                if (ecn_reg) begin
                    win_cong_next = win_cong_reg + {32'b0, delta_reg};
                    tot_cong_next = tot_cong_reg + {32'b0, delta_reg};
                end
                if (elapsed_reg >= win_ticks_reg) begin
                    state_next = S_RANGE;
                end else begin
                    closed_next = 1'b0;
                    state_next  = S_OUT;
                end
            end
            // empty window or saturated rate skip the divide
            S_RANGE: begin
                if (win_total_reg == '0 || alu_carry) begin
                    rate_next  = (win_total_reg == '0) ? '0 : RATE_FULL;
                    acc_next   = {10'b0, win_cong_reg, 6'b0};
                    opnd_next  = {16'b0, win_total_reg};
                    step_next  = '0;
                    state_next = S_ALERT;
                end else begin
                    acc_next   = {2'b0, win_cong_reg, 14'b0};
                    step_next  = '0;
                    state_next = S_SCALE;
                end
            end
            // congested * 25600 as three shifted terms
            S_SCALE: begin
                acc_next = alu_res;
                if (step_reg == 4'd0) begin
                    step_next = 4'd1;
                end else begin
                    opnd_next  = {2'b0, win_total_reg, 14'b0};
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end
            // restoring divide, one quotient bit a cycle
            S_DIV: begin
                if (alu_carry) begin
                    acc_next = alu_res;
                end
                quo_next  = {quo_reg[RATE_W-2:0], alu_carry};
                opnd_next = opnd_reg >> 1;
                if (step_reg == DIV_LAST) begin
                    rate_next  = {quo_reg[RATE_W-2:0], alu_carry};
                    acc_next   = {10'b0, win_cong_reg, 6'b0};
                    opnd_next  = {16'b0, win_total_reg};
                    step_next  = '0;
                    state_next = S_ALERT;
                end else begin
                    step_next = step_reg + 4'd1;
                end
            end
            // 100 * congested - threshold * total, sign decides the alert
            S_ALERT: begin
                acc_next = alu_res;
                if (step_reg >= 4'd2) begin
                    opnd_next = opnd_reg << 1;
                end
                if (step_reg == ALERT_LAST) begin
                    alert_next     = !alu_res[ACC_W-1] && (alu_res != '0);
                    win_total_next = '0;
                    win_cong_next  = '0;
                    elapsed_next   = '0;
                    closed_next    = 1'b1;
                    state_next     = S_OUT;
                end else begin
                    step_next = step_reg + 4'd1;
                end
            end
            // load the output register once it is free
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0, alert_reg, rate_reg, closed_reg, tot_cong_reg,
                                     tot_rx_reg, ecn_reg, delta_reg, seq_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            win_ticks_reg <= WINDOW_TICKS_RST;
            thr_reg       <= ALERT_THR_RST;
            have_base_reg <= 1'b0;
            last_seq_reg  <= '0;
            win_total_reg <= '0;
            win_cong_reg  <= '0;
            elapsed_reg   <= '0;
            tot_rx_reg    <= '0;
            tot_cong_reg  <= '0;
            rate_reg      <= '0;
            alert_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            win_ticks_reg <= win_ticks_next;
            thr_reg       <= thr_next;
            have_base_reg <= have_base_next;
            last_seq_reg  <= last_seq_next;
            win_total_reg <= win_total_next;
            win_cong_reg  <= win_cong_next;
            elapsed_reg   <= elapsed_next;
            tot_rx_reg    <= tot_rx_next;
            tot_cong_reg  <= tot_cong_next;
            rate_reg      <= rate_next;
            alert_reg     <= alert_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        seq_reg     <= seq_next;
        delta_reg   <= delta_next;
        ecn_reg     <= ecn_next;
        closed_reg  <= closed_next;
        acc_reg     <= acc_next;
        opnd_reg    <= opnd_next;
        quo_reg     <= quo_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

`default_nettype wire

// ----- sv/wcrm_alu.sv -----
// ----------------------------------------------------------------------------
// wcrm_alu
// Shared wide add/subtract unit; carry out doubles as the a >= b flag.
// ----------------------------------------------------------------------------
`default_nettype none

module wcrm_alu
    import wcrm_pkg::*;
(
    input  wire logic [ACC_W-1:0] a,
    input  wire logic [ACC_W-1:0] b,
    input  wire alu_ctl_t         ctl,
    output logic      [ACC_W-1:0] res,
    output logic                  carry
);

    logic [ACC_W-1:0] b_op;
    logic [ACC_W:0]   full;

    // two's complement subtract by inverting b and injecting a carry
    assign b_op  = ctl.sub ? ~b : b;
    assign full  = {1'b0, a} + {1'b0, b_op} + {{ACC_W{1'b0}}, ctl.sub};
    assign res   = full[ACC_W-1:0];
    assign carry = full[ACC_W];

endmodule

`default_nettype wire

// ----- sv/wcrm_checker.sv -----
// ----------------------------------------------------------------------------
// wcrm_checker
// Port-level checks on the result stream of the congestion rate monitor.
// ----------------------------------------------------------------------------
`default_nettype none

`include "windowed_congestion_rate_monitor_core_assert.svh"

module wcrm_checker
    import wcrm_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire logic [M_DATA_W-1:0] m_tdata
);

    // a stalled result holds its transaction
    `WCRM_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // every counted observation moves the sequence on
    `WCRM_ASSERT_NOW(a_delta, aclk, aresetn, m_tvalid, m_tdata[63:32] != 32'd0, "zero packet delta reported")

    // rate never exceeds one hundred percent
    `WCRM_ASSERT_NOW(a_rate, aclk, aresetn, m_tvalid, m_tdata[208:194] <= RATE_FULL, "rate above one hundred percent")

    // no result straight out of reset
    `WCRM_ASSERT_ALWAYS(a_reset, aclk, $past(!aresetn), !m_tvalid, "result valid after reset")

endmodule

bind windowed_congestion_rate_monitor_core wcrm_checker u_wcrm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- test/windowed_congestion_rate_monitor_core_tb.sv -----
// ----------------------------------------------------------------------------
// windowed_congestion_rate_monitor_core_tb
// Self-checking bench for the congestion rate monitor. A directed list covers
// the baseline, repeated and wrapping sequence numbers, the zero and full
// window lengths, threshold extremes and unused register indexes. Random
// phases with varied settings follow. Every result is checked, field by
// field, against a behavioural model of the monitor or a typed directed
// result, with random idling on both streams but in the last phase.
// ----------------------------------------------------------------------------
module windowed_congestion_rate_monitor_core_tb;
    import wcrm_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 75;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 2'd3;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq_seen;
        logic [SEQ_W-1:0]  packet_delta;
        logic              was_congested;
        logic [CNT_W-1:0]  lifetime_received;
        logic [CNT_W-1:0]  lifetime_congested;
        logic              window_closed;
        logic [RATE_W-1:0] rate_q8;
        logic              alert;
    } obs_result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic                  cmd;
        logic [SEQ_W-1:0]      seq;
        logic                  ecn;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  fixed;
        obs_result_t           want;
    } stim_row_t;

    // dut ports
    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // model state and register copies
    logic [TICK_W-1:0] win_len    = WINDOW_TICKS_RST;
    logic [THR_W-1:0]  thr_pct    = ALERT_THR_RST;
    logic              have_base  = 1'b0;
    logic [SEQ_W-1:0]  prev_seq   = '0;
    logic [CNT_W-1:0]  win_rx     = '0;
    logic [CNT_W-1:0]  win_cong   = '0;
    logic [CNT_W-1:0]  life_rx    = '0;
    logic [CNT_W-1:0]  life_cong  = '0;
    logic [TICK_W-1:0] ticks_seen = '0;
    logic [RATE_W-1:0] rate_held  = '0;
    logic              alert_held = 1'b0;

    obs_result_t due_results [$];
    int          mismatches      = 0;
    int          results_checked = 0;
    int          items_sent      = 0;
    int          ticks_sent      = 0;
    int          windows_closed  = 0;
    int          cycle_count     = 0;
    int          rx_stall        = 0;
    bit          quiet_run       = 1'b0;

    windowed_congestion_rate_monitor_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // seq_number[31:0], ecn_flag[32]
        .s_tuser   (s_tuser),   // command[0]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // seq_seen, packet_delta, was_congested, lifetime_received,
                                // lifetime_congested, window_closed, rate_q8, alert
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // congested percent in q8, truncated, full scale when congested >= total
    function automatic logic [RATE_W-1:0] q8_percent(input logic [CNT_W-1:0] cong,
                                                     input logic [CNT_W-1:0] total);
        logic [2*CNT_W-1:0] quot;
        if (total == '0) return '0;
        if (cong >= total) return RATE_FULL;
        quot = {{CNT_W{1'b0}}, cong} * RATE_FULL / {{CNT_W{1'b0}}, total};
        return quot[RATE_W-1:0];
    endfunction

    // exact test of 100 * congested > threshold * total
    function automatic logic over_threshold(input logic [CNT_W-1:0] cong,
                                            input logic [CNT_W-1:0] total,
                                            input logic [THR_W-1:0] thr);
        logic [2*CNT_W-1:0] lhs;
        logic [2*CNT_W-1:0] rhs;
        lhs = {{CNT_W{1'b0}}, cong} * 8'd100;
        rhs = {{CNT_W{1'b0}}, total} * thr;
        return lhs > rhs;
    endfunction

    // advance the model by one accepted item; returns 1 when a result is due
    function automatic logic account_item(input logic cmd, input logic [SEQ_W-1:0] seq,
                                          input logic ecn, output obs_result_t res);
        logic [SEQ_W-1:0] delta;
        res = '0;
        if (cmd == CMD_TICK) begin
            if (ticks_seen != '1) ticks_seen++;
            return 1'b0;
        end
        if (!have_base) begin
            have_base = 1'b1;
            prev_seq  = seq;
            return 1'b0;
        end
        if (seq == prev_seq) return 1'b0;

        delta    = seq - prev_seq;
        prev_seq = seq;
        win_rx  += delta;
        life_rx += delta;
        if (ecn) begin
            win_cong  += delta;
            life_cong += delta;
        end
        // window close
        if (ticks_seen >= win_len) begin
            rate_held           = q8_percent(win_cong, win_rx);
            alert_held          = over_threshold(win_cong, win_rx, thr_pct);
            win_rx              = '0;
            win_cong            = '0;
            ticks_seen          = '0;
            res.window_closed   = 1'b1;
            windows_closed++;
        end
        res.seq_seen           = seq;
        res.packet_delta       = delta;
        res.was_congested      = ecn;
        res.lifetime_received  = life_rx;
        res.lifetime_congested = life_cong;
        res.rate_q8            = rate_held;
        res.alert              = alert_held;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input logic [CNT_W-1:0] got,
                                 input logic [CNT_W-1:0] want);
        mismatches++;
        $display("[%0t] result %0d: %s is %0h, predicted %0h",
                 $time, results_checked, what, got, want);
    endtask

    // drop valid and let one edge pass
    task automatic stream_pause();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // wait until every due result has arrived and the block has gone quiet
    task automatic settle();
        stream_pause();
        while (due_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_WINDOW_TICKS) win_len = data;
        else if (idx == REG_ALERT_THR) thr_pct = data[THR_W-1:0];
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // one input transaction; a typed result replaces the model's when fixed is set
    task automatic send_item(input logic cmd, input logic [SEQ_W-1:0] seq, input logic ecn,
                             input logic fixed, input obs_result_t fixed_want);
        obs_result_t want;
        logic        produced;
        int          gap;
        if (!quiet_run && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_DATA_W-SEQ_W-1){1'b0}}, ecn, seq};
        do @(posedge aclk); while (!s_tready);
        produced = account_item(cmd, seq, ecn, want);
        if (produced) due_results.push_back(fixed ? fixed_want : want);
        items_sent++;
        if (cmd == CMD_TICK) ticks_sent++;
    endtask

    function automatic stim_row_t tick_row();
        stim_row_t r;
        r      = '0;
        r.kind = ROW_ITEM;
        r.cmd  = CMD_TICK;
        return r;
    endfunction

    function automatic stim_row_t pkt_row(input logic [SEQ_W-1:0] seq, input logic ecn);
        stim_row_t r;
        r      = '0;
        r.kind = ROW_ITEM;
        r.cmd  = CMD_PACKET;
        r.seq  = seq;
        r.ecn  = ecn;
        return r;
    endfunction

    function automatic stim_row_t checked_row(input logic [SEQ_W-1:0] seq, input logic ecn,
                                              input obs_result_t want);
        stim_row_t r;
        r       = pkt_row(seq, ecn);
        r.fixed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        stim_row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    // result sink with bursts of back-pressure
    always @(posedge aclk) begin
        if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_tready <= 1'b0;
        end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
            rx_stall <= $urandom_range(0, 4);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare each result transaction with the oldest due result
    always @(posedge aclk) begin : result_check
        obs_result_t got;
        obs_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.seq_seen           = m_tdata[31:0];
            got.packet_delta       = m_tdata[63:32];
            got.was_congested      = m_tdata[64];
            got.lifetime_received  = m_tdata[128:65];
            got.lifetime_congested = m_tdata[192:129];
            got.window_closed      = m_tdata[193];
            got.rate_q8            = m_tdata[208:194];
            got.alert              = m_tdata[209];
            results_checked++;
            if (due_results.size() == 0) begin
                flag_mismatch("result with none due, seq_seen", CNT_W'(got.seq_seen), '0);
            end else begin
                want = due_results.pop_front();
                if (got.seq_seen !== want.seq_seen)
                    flag_mismatch("seq_seen", CNT_W'(got.seq_seen), CNT_W'(want.seq_seen));
                if (got.packet_delta !== want.packet_delta)
                    flag_mismatch("packet_delta", CNT_W'(got.packet_delta),
                                  CNT_W'(want.packet_delta));
                if (got.was_congested !== want.was_congested)
                    flag_mismatch("was_congested", CNT_W'(got.was_congested),
                                  CNT_W'(want.was_congested));
                if (got.lifetime_received !== want.lifetime_received)
                    flag_mismatch("lifetime_received", got.lifetime_received,
                                  want.lifetime_received);
                if (got.lifetime_congested !== want.lifetime_congested)
                    flag_mismatch("lifetime_congested", got.lifetime_congested,
                                  want.lifetime_congested);
                if (got.window_closed !== want.window_closed)
                    flag_mismatch("window_closed", CNT_W'(got.window_closed),
                                  CNT_W'(want.window_closed));
                if (got.rate_q8 !== want.rate_q8)
                    flag_mismatch("rate_q8", CNT_W'(got.rate_q8), CNT_W'(want.rate_q8));
                if (got.alert !== want.alert)
                    flag_mismatch("alert", CNT_W'(got.alert), CNT_W'(want.alert));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout: %0d results still due after %0d cycles",
                     due_results.size(), cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        stim_row_t        dir_rows [$];
        obs_result_t      nil;
        logic [SEQ_W-1:0] seq;
        logic [CFG_DATA_W-1:0] data;
        int               pick;
        int               ecn_pct;

        nil = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed list, reset register values at first
        dir_rows.push_back(tick_row());
        dir_rows.push_back(pkt_row(32'hFFFF_FFF0, 1'b0));          // baseline only
        dir_rows.push_back(pkt_row(32'hFFFF_FFF0, 1'b1));          // unchanged, ignored
        dir_rows.push_back(checked_row(32'h0000_0005, 1'b1,        // wraps past zero
            obs_result_t'{32'd5, 32'd21, 1'b1, 64'd21, 64'd21, 1'b0, 15'd0, 1'b0}));
        dir_rows.push_back(checked_row(32'h0000_0004, 1'b0,        // largest delta
            obs_result_t'{32'd4, 32'hFFFF_FFFF, 1'b0, 64'h1_0000_0014, 64'd21,
                          1'b0, 15'd0, 1'b0}));
        dir_rows.push_back(cfg_row(REG_WINDOW_TICKS, 16'd0));      // every packet closes
        dir_rows.push_back(pkt_row(32'h0000_0000, 1'b1));
        dir_rows.push_back(checked_row(32'h0000_0001, 1'b1,        // all congested
            obs_result_t'{32'd1, 32'd1, 1'b1, 64'h2_0000_0011, 64'h1_0000_0012,
                          1'b1, RATE_FULL, 1'b1}));
        dir_rows.push_back(cfg_row(REG_ALERT_THR, 16'd100));
        dir_rows.push_back(pkt_row(32'h0000_0002, 1'b1));
        dir_rows.push_back(cfg_row(REG_ALERT_THR, 16'd127));       // threshold above hundred
        dir_rows.push_back(pkt_row(32'h0000_0003, 1'b1));
        dir_rows.push_back(cfg_row(REG_ALERT_THR, 16'd0));
        dir_rows.push_back(pkt_row(32'h0000_0004, 1'b0));
        dir_rows.push_back(pkt_row(32'h0000_0005, 1'b1));
        dir_rows.push_back(cfg_row(REG_UNUSED_LO, 16'h0003));      // ignored
        dir_rows.push_back(cfg_row(REG_UNUSED_HI, 16'hFFFF));      // ignored
        dir_rows.push_back(cfg_row(REG_WINDOW_TICKS, 16'd2));
        dir_rows.push_back(pkt_row(32'h0000_0008, 1'b1));
        dir_rows.push_back(tick_row());
        dir_rows.push_back(pkt_row(32'h0000_000B, 1'b0));
        dir_rows.push_back(tick_row());
        dir_rows.push_back(pkt_row(32'h0000_000E, 1'b0));          // closes, one third
        dir_rows.push_back(cfg_row(REG_ALERT_THR, 16'hFFB3));      // upper data bits dropped
        dir_rows.push_back(cfg_row(REG_WINDOW_TICKS, 16'hFFFF));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                settle();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                send_item(dir_rows[i].cmd, dir_rows[i].seq, dir_rows[i].ecn,
                          dir_rows[i].fixed, dir_rows[i].want);
            end
        end

        // random phases, each with fresh register settings
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            quiet_run = (ph == PHASES - 1);
            case ($urandom_range(0, 3))
                0:       data = '0;
                1:       data = 16'd1;
                default: data = CFG_DATA_W'($urandom_range(2, 6));
            endcase
            write_reg(REG_WINDOW_TICKS, data);
            data = CFG_DATA_W'($urandom);
            case ($urandom_range(0, 5))
                0:       data[THR_W-1:0] = '0;
                1:       data[THR_W-1:0] = '1;
                default: data[THR_W-1:0] = THR_W'($urandom_range(0, 100));
            endcase
            write_reg(REG_ALERT_THR, data);
            if ($urandom_range(0, 1))
                write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI,
                          CFG_DATA_W'($urandom));

            ecn_pct = $urandom_range(0, 100);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    send_item(CMD_TICK, $urandom, 1'($urandom_range(0, 1)), 1'b0, nil);
                end else begin
                    if (pick < 38)      seq = prev_seq;
                    else if (pick < 45) seq = $urandom;
                    else if (pick < 90) seq = prev_seq + $urandom_range(1, 16);
                    else                seq = prev_seq + $urandom_range(1, 1 << 20);
                    send_item(CMD_PACKET, seq, $urandom_range(0, 99) < ecn_pct, 1'b0, nil);
                end
            end
        end

        settle();
        $display("run covered %0d input transactions (%0d ticks), %0d results, %0d window closes",
                 items_sent, ticks_sent, results_checked, windows_closed);
        $display("window lengths 0, 1 and small; thresholds 0 to 127; unused indexes");
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/wcrm_pkg.sv
sv/wcrm_alu.sv
sv/windowed_congestion_rate_monitor_core.sv
sv/wcrm_checker.sv
test/windowed_congestion_rate_monitor_core_tb.sv
